### hdl/i2cscr_pkg.sv
`default_nettype none

package i2cscr_pkg;

  // bus event codes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SHIFT  = 2'd1,
    OP_STOP   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_e;

  // shifter action codes
  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND_ACK  = 3'd1,
    ACT_SEND_DATA = 3'd2,
    ACT_READ_ACK  = 3'd3,
    ACT_READ_DATA = 3'd4,
    ACT_RELEASE   = 3'd5
  } action_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDRESS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SET_LED_CODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLEAR_LED_CODE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_CODE      = 3'd4;

  // configuration reset values
  localparam logic [6:0] OWN_ADDRESS_RST    = 7'd32;
  localparam logic [7:0] SET_LED_CODE_RST   = 8'h01;
  localparam logic [7:0] CLEAR_LED_CODE_RST = 8'h02;
  localparam logic [7:0] READ_SAMPLE_RST    = 8'hC0;
  localparam logic [7:0] IDLE_CODE_RST      = 8'h00;

  // protocol constants
  localparam logic [7:0] READ_THRESHOLD = 8'hC0;
  localparam logic [7:0] GENERAL_CALL   = 8'h00;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic       led_on;
    logic       stop_seen;
  } out_t;

endpackage

`default_nettype wire

### hdl/i2c_slave_command_responder.sv
// Byte-level I2C slave engine driven by bus events.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
// transaction: start, completed shift with the shifted byte, stop, or a new
// sample. Output channel (out_valid_o / out_stall_i / out_data_o) returns one
// result per event: shifter action, byte to transmit, LED level, stop flag.
// Configuration writes (cfg_valid_i / cfg_ready_o, index and data) are always
// ready; the user must issue them only while no event is in flight, which the
// block itself does not enforce. An accepted event is held in the input
// register; its result is written to the result register once that is free.
// Throughput: one event per cycle while the receiver does not stall; an
// input register and a result register in series, with the combinational
// phase update between them.
// The input side stalls only when its register is full and the result
// register is held by a stalled receiver; a held result stays unchanged.
// Reset: address 32, set LED 0x01, clear LED 0x02, read sample 0xC0, idle
// 0x00; phase check address, no pending command, sample zero, LED off,
// both pipeline registers empty.
`default_nettype none

module i2c_slave_command_responder (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire i2cscr_pkg::in_t                    in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output i2cscr_pkg::out_t                        out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [i2cscr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [7:0]                         cfg_data_i
);

  typedef enum logic [2:0] {
    PH_CHECK_ADDR = 3'd0,
    PH_SEND_DATA  = 3'd1,
    PH_PREP_ACK   = 3'd2,
    PH_CHECK_ACK  = 3'd3,
    PH_REQ_DATA   = 3'd4,
    PH_GET_DATA   = 3'd5
  } phase_e;

  logic [6:0] own_addr_q;
  logic [7:0] set_code_q;
  logic [7:0] clr_code_q;
  logic [7:0] rd_code_q;
  logic [7:0] idle_code_q;

  logic             s1_valid_q;
  i2cscr_pkg::in_t  s1_data_q;
  logic             advance;

  phase_e           phase_q, phase_d;
  logic [7:0]       pend_q, pend_d;
  logic [7:0]       sample_q, sample_d;
  logic             led_q, led_d;
  logic             out_valid_q;
  i2cscr_pkg::out_t out_q, out_d;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= i2cscr_pkg::OWN_ADDRESS_RST;
      set_code_q  <= i2cscr_pkg::SET_LED_CODE_RST;
      clr_code_q  <= i2cscr_pkg::CLEAR_LED_CODE_RST;
      rd_code_q   <= i2cscr_pkg::READ_SAMPLE_RST;
      idle_code_q <= i2cscr_pkg::IDLE_CODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        i2cscr_pkg::CFG_OWN_ADDRESS:    own_addr_q  <= cfg_data_i[6:0];
        i2cscr_pkg::CFG_SET_LED_CODE:   set_code_q  <= cfg_data_i;
        i2cscr_pkg::CFG_CLEAR_LED_CODE: clr_code_q  <= cfg_data_i;
        i2cscr_pkg::CFG_READ_SAMPLE:    rd_code_q   <= cfg_data_i;
        i2cscr_pkg::CFG_IDLE_CODE:      idle_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: the held event moves on when the result register is free
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // event decode and phase update
  always_comb begin
    phase_d           = phase_q;
    pend_d            = pend_q;
    sample_d          = sample_q;
    led_d             = led_q;
    out_d.action      = i2cscr_pkg::ACT_NONE;
    out_d.tx_byte     = 8'h00;
    out_d.stop_seen   = 1'b0;
    case (s1_data_q.op)
      i2cscr_pkg::OP_START: begin
        phase_d      = PH_CHECK_ADDR;
        out_d.action = i2cscr_pkg::ACT_READ_DATA;
      end
      i2cscr_pkg::OP_SHIFT: begin
        case (phase_q)
          PH_CHECK_ADDR: begin
            if (s1_data_q.value == i2cscr_pkg::GENERAL_CALL ||
                s1_data_q.value[7:1] == own_addr_q) begin
              if (s1_data_q.value[0]) begin
                // read request needs an armed command
                if (pend_q >= i2cscr_pkg::READ_THRESHOLD) begin
                  phase_d      = PH_SEND_DATA;
                  out_d.action = i2cscr_pkg::ACT_SEND_ACK;
                end else begin
                  phase_d      = PH_CHECK_ADDR;
                  out_d.action = i2cscr_pkg::ACT_RELEASE;
                end
              end else begin
                phase_d      = PH_REQ_DATA;
                out_d.action = i2cscr_pkg::ACT_SEND_ACK;
              end
            end else begin
              phase_d      = PH_CHECK_ADDR;
              out_d.action = i2cscr_pkg::ACT_RELEASE;
            end
          end
          PH_CHECK_ACK, PH_SEND_DATA: begin
            if (phase_q == PH_CHECK_ACK && s1_data_q.value[0]) begin
              // master nack ends the read
              phase_d      = PH_CHECK_ADDR;
              out_d.action = i2cscr_pkg::ACT_RELEASE;
            end else begin
              // shifter keeps its byte unless a sample read is armed
              out_d.tx_byte = s1_data_q.value;
              if (pend_q == rd_code_q) begin
                pend_d        = idle_code_q;
                out_d.tx_byte = sample_q;
              end
              phase_d      = PH_PREP_ACK;
              out_d.action = i2cscr_pkg::ACT_SEND_DATA;
            end
          end
          PH_PREP_ACK: begin
            phase_d      = PH_CHECK_ACK;
            out_d.action = i2cscr_pkg::ACT_READ_ACK;
          end
          PH_REQ_DATA: begin
            phase_d      = PH_GET_DATA;
            out_d.action = i2cscr_pkg::ACT_READ_DATA;
          end
          PH_GET_DATA: begin
            // command byte; led commands take priority
            pend_d       = s1_data_q.value;
            phase_d      = PH_REQ_DATA;
            out_d.action = i2cscr_pkg::ACT_SEND_ACK;
            if (s1_data_q.value == set_code_q) begin
              led_d  = 1'b1;
              pend_d = idle_code_q;
            end else if (s1_data_q.value == clr_code_q) begin
              led_d  = 1'b0;
              pend_d = idle_code_q;
            end
          end
          default: begin
            out_d.action = i2cscr_pkg::ACT_NONE;
          end
        endcase
      end
      i2cscr_pkg::OP_STOP: begin
        out_d.action    = i2cscr_pkg::ACT_RELEASE;
        out_d.stop_seen = 1'b1;
      end
      i2cscr_pkg::OP_SAMPLE: begin
        sample_d = s1_data_q.value;
      end
      default: ;
    endcase
    out_d.led_on = led_d;
  end

  // engine state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CHECK_ADDR;
      pend_q      <= i2cscr_pkg::IDLE_CODE_RST;
      sample_q    <= 8'h00;
      led_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q  <= phase_d;
        pend_q   <= pend_d;
        sample_q <= sample_d;
        led_q    <= led_d;
        out_q    <= out_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a stop result always releases the bus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stop_seen |-> out_data_o.action == i2cscr_pkg::ACT_RELEASE)
    else $error("stop result without release action");

  // transmit byte is zero unless data is being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != i2cscr_pkg::ACT_SEND_DATA
      |-> out_data_o.tx_byte == 8'h00)
    else $error("tx byte set without send data");

  // led level changes only with an acknowledged command byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && led_d != led_q |=> out_data_o.action == i2cscr_pkg::ACT_SEND_ACK)
    else $error("led changed outside a command write");

endmodule

`default_nettype wire

### tb/i2c_slave_command_responder_tb.sv
`default_nettype none

module i2c_slave_command_responder_tb;

  localparam int unsigned MaxWait = 17;
  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned ItemsPerSetting = 250;
  localparam int unsigned NumSettings = 7;
  localparam int unsigned MaxPrinted = 100;

  // bus phases of the responder
  typedef enum logic [2:0] {
    PH_CHECK_ADDR = 3'd0,
    PH_SEND_DATA  = 3'd1,
    PH_PREP_ACK   = 3'd2,
    PH_CHECK_ACK  = 3'd3,
    PH_REQ_DATA   = 3'd4,
    PH_GET_DATA   = 3'd5
  } phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  i2cscr_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  i2cscr_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [i2cscr_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  i2c_slave_command_responder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // shadow copy of the register file
  logic [6:0] c_addr = i2cscr_pkg::OWN_ADDRESS_RST;
  logic [7:0] c_set = i2cscr_pkg::SET_LED_CODE_RST;
  logic [7:0] c_clr = i2cscr_pkg::CLEAR_LED_CODE_RST;
  logic [7:0] c_read = i2cscr_pkg::READ_SAMPLE_RST;
  logic [7:0] c_idle = i2cscr_pkg::IDLE_CODE_RST;

  // shadow copy of the responder state
  phase_e m_phase = PH_CHECK_ADDR;
  logic [7:0] m_command = i2cscr_pkg::IDLE_CODE_RST;
  logic [7:0] m_sample = '0;
  logic m_led = 1'b0;

  i2cscr_pkg::in_t bus_events[$];
  i2cscr_pkg::out_t reply_queue[$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned error_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit drv_eager = 1'b0;
  bit mon_eager = 1'b0;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_wait(input bit eager);
    return eager ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // byte loaded for transmit: armed sample once, else the shifter keeps its byte
  function automatic logic [7:0] load_shifter(input logic [7:0] shifted);
    logic [7:0] tx;
    tx = shifted;
    if (m_command == c_read) begin
      m_command = c_idle;
      tx = m_sample;
    end
    m_phase = PH_PREP_ACK;
    return tx;
  endfunction

  // next reply of the responder for one bus event
  function automatic i2cscr_pkg::out_t respond_to_event(input i2cscr_pkg::in_t ev);
    i2cscr_pkg::out_t r;
    r = '0;
    case (ev.op)
      i2cscr_pkg::OP_START: begin
        m_phase = PH_CHECK_ADDR;
        r.action = i2cscr_pkg::ACT_READ_DATA;
      end
      i2cscr_pkg::OP_SHIFT: begin
        case (m_phase)
          PH_CHECK_ADDR: begin
            if (ev.value == i2cscr_pkg::GENERAL_CALL || ev.value[7:1] == c_addr) begin
              if (ev.value[0]) begin
                // read only with a high enough command pending
                if (m_command >= i2cscr_pkg::READ_THRESHOLD) begin
                  m_phase = PH_SEND_DATA;
                  r.action = i2cscr_pkg::ACT_SEND_ACK;
                end else begin
                  r.action = i2cscr_pkg::ACT_RELEASE;
                end
              end else begin
                m_phase = PH_REQ_DATA;
                r.action = i2cscr_pkg::ACT_SEND_ACK;
              end
            end else begin
              r.action = i2cscr_pkg::ACT_RELEASE;
            end
          end
          PH_CHECK_ACK: begin
            if (ev.value[0]) begin
              m_phase = PH_CHECK_ADDR;
              r.action = i2cscr_pkg::ACT_RELEASE;
            end else begin
              r.tx_byte = load_shifter(ev.value);
              r.action = i2cscr_pkg::ACT_SEND_DATA;
            end
          end
          PH_SEND_DATA: begin
            r.tx_byte = load_shifter(ev.value);
            r.action = i2cscr_pkg::ACT_SEND_DATA;
          end
          PH_PREP_ACK: begin
            m_phase = PH_CHECK_ACK;
            r.action = i2cscr_pkg::ACT_READ_ACK;
          end
          PH_REQ_DATA: begin
            m_phase = PH_GET_DATA;
            r.action = i2cscr_pkg::ACT_READ_DATA;
          end
          PH_GET_DATA: begin
            // set led wins over clear led, both over read arming
            m_command = ev.value;
            m_phase = PH_REQ_DATA;
            r.action = i2cscr_pkg::ACT_SEND_ACK;
            if (ev.value == c_set) begin
              m_led = 1'b1;
              m_command = c_idle;
            end else if (ev.value == c_clr) begin
              m_led = 1'b0;
              m_command = c_idle;
            end
          end
          default: r.action = i2cscr_pkg::ACT_NONE;
        endcase
      end
      i2cscr_pkg::OP_STOP: begin
        r.action = i2cscr_pkg::ACT_RELEASE;
        r.stop_seen = 1'b1;
      end
      default: m_sample = ev.value;
    endcase
    r.led_on = m_led;
    return r;
  endfunction

  // event driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        reply_queue.push_back(respond_to_event(in_data));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (bus_events.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= bus_events.pop_front();
          if ($urandom_range(0, 39) == 0) drv_eager = !drv_eager;
          gap_left <= draw_wait(drv_eager);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin : monitor
    int unsigned n;
    i2cscr_pkg::out_t got;
    i2cscr_pkg::out_t want;
    n = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (reply_queue.size() == 0) begin
          flag_error("reply with no bus event outstanding");
        end else begin
          want = reply_queue.pop_front();
          if (got.action !== want.action)
            flag_error($sformatf("action: got %0d, want %0d", got.action, want.action));
          if (got.tx_byte !== want.tx_byte)
            flag_error($sformatf("tx_byte: got %0h, want %0h", got.tx_byte, want.tx_byte));
          if (got.led_on !== want.led_on)
            flag_error($sformatf("led_on: got %0b, want %0b", got.led_on, want.led_on));
          if (got.stop_seen !== want.stop_seen)
            flag_error($sformatf("stop_seen: got %0b, want %0b", got.stop_seen,
                                 want.stop_seen));
        end
        if ($urandom_range(0, 39) == 0) mon_eager = !mon_eager;
        n = draw_wait(mon_eager);
      end else if (stall_left != 0) begin
        n = stall_left - 1;
      end
      stall_left <= n;
      out_stall <= (n != 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_event(input i2cscr_pkg::op_e op, input logic [7:0] value);
    i2cscr_pkg::in_t ev;
    ev.op = op;
    ev.value = value;
    bus_events.push_back(ev);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || reply_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [i2cscr_pkg::CfgIdxW-1:0] idx,
                           input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      i2cscr_pkg::CFG_OWN_ADDRESS:    c_addr = data[6:0];
      i2cscr_pkg::CFG_SET_LED_CODE:   c_set = data;
      i2cscr_pkg::CFG_CLEAR_LED_CODE: c_clr = data;
      i2cscr_pkg::CFG_READ_SAMPLE:    c_read = data;
      i2cscr_pkg::CFG_IDLE_CODE:      c_idle = data;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [6:0] addr, input logic [7:0] set_code,
                           input logic [7:0] clr_code, input logic [7:0] rd_code,
                           input logic [7:0] idle_v);
    logic [i2cscr_pkg::CfgIdxW-1:0] spare;
    write_reg(i2cscr_pkg::CFG_OWN_ADDRESS, {1'($urandom), addr});
    write_reg(i2cscr_pkg::CFG_SET_LED_CODE, set_code);
    write_reg(i2cscr_pkg::CFG_CLEAR_LED_CODE, clr_code);
    write_reg(i2cscr_pkg::CFG_READ_SAMPLE, rd_code);
    write_reg(i2cscr_pkg::CFG_IDLE_CODE, idle_v);
    // indexes past the last register are ignored
    do spare = i2cscr_pkg::CfgIdxW'($urandom); while (spare <= i2cscr_pkg::CFG_IDLE_CODE);
    write_reg(spare, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_address(input logic rw);
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return i2cscr_pkg::GENERAL_CALL;
    if (sel == 1) return 8'($urandom);
    return {c_addr, rw};
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 5))
      0: return c_set;
      1: return c_clr;
      2: return c_read;
      3: return {2'b11, 6'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  // write transfer: ack slot then command byte, per byte
  task automatic gen_write(input bit arm);
    int unsigned nbytes;
    nbytes = $urandom_range(1, 3);
    push_event(i2cscr_pkg::OP_START, 8'($urandom));
    push_event(i2cscr_pkg::OP_SHIFT, pick_address(1'b0));
    repeat (nbytes) begin
      push_event(i2cscr_pkg::OP_SHIFT, 8'($urandom));
      push_event(i2cscr_pkg::OP_SHIFT, pick_command());
    end
    if (arm) begin
      push_event(i2cscr_pkg::OP_SHIFT, 8'($urandom));
      push_event(i2cscr_pkg::OP_SHIFT, c_read);
    end
    if ($urandom_range(0, 7) != 0) push_event(i2cscr_pkg::OP_STOP, 8'($urandom));
  endtask

  // read transfer: bytes acked by the master, the last one nacked
  task automatic gen_read();
    int unsigned nbytes;
    nbytes = $urandom_range(1, 4);
    push_event(i2cscr_pkg::OP_START, 8'($urandom));
    push_event(i2cscr_pkg::OP_SHIFT, pick_address(1'b1));
    push_event(i2cscr_pkg::OP_SHIFT, 8'($urandom));
    repeat (nbytes - 1) begin
      push_event(i2cscr_pkg::OP_SHIFT, 8'($urandom));
      push_event(i2cscr_pkg::OP_SHIFT, {7'($urandom), 1'b0});
    end
    push_event(i2cscr_pkg::OP_SHIFT, 8'($urandom));
    push_event(i2cscr_pkg::OP_SHIFT, {7'($urandom), 1'b1});
    if ($urandom_range(0, 7) != 0) push_event(i2cscr_pkg::OP_STOP, 8'($urandom));
  endtask

  task automatic gen_transfer();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) push_event(i2cscr_pkg::OP_SAMPLE, 8'($urandom));
    if (kind < 4) begin
      gen_write(1'b0);
    end else if (kind < 8) begin
      gen_write(1'b1);
      gen_read();
    end else if (kind == 8) begin
      gen_read();
    end else begin
      // noise: arbitrary events
      repeat ($urandom_range(1, 4))
        push_event(i2cscr_pkg::op_e'($urandom_range(i2cscr_pkg::OP_START,
                                                    i2cscr_pkg::OP_SAMPLE)),
                   8'($urandom));
    end
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned mark;
    logic [7:0] code;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // write transfer toggling the led, sample stored first
    push_event(i2cscr_pkg::OP_SAMPLE, 8'hA5);
    push_event(i2cscr_pkg::OP_START, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, {i2cscr_pkg::OWN_ADDRESS_RST, 1'b0});
    push_event(i2cscr_pkg::OP_SHIFT, 8'hFF);
    push_event(i2cscr_pkg::OP_SHIFT, i2cscr_pkg::SET_LED_CODE_RST);
    push_event(i2cscr_pkg::OP_SHIFT, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, i2cscr_pkg::CLEAR_LED_CODE_RST);
    push_event(i2cscr_pkg::OP_STOP, 8'hFF);
    // read refused with nothing armed
    push_event(i2cscr_pkg::OP_START, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, {i2cscr_pkg::OWN_ADDRESS_RST, 1'b1});
    // general call write arming a sample read
    push_event(i2cscr_pkg::OP_START, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, i2cscr_pkg::GENERAL_CALL);
    push_event(i2cscr_pkg::OP_SHIFT, 8'h5A);
    push_event(i2cscr_pkg::OP_SHIFT, i2cscr_pkg::READ_SAMPLE_RST);
    push_event(i2cscr_pkg::OP_STOP, 8'h00);
    // read: sample once, then echo of the shifted byte, then nack
    push_event(i2cscr_pkg::OP_START, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, {i2cscr_pkg::OWN_ADDRESS_RST, 1'b1});
    push_event(i2cscr_pkg::OP_SHIFT, 8'h3C);
    push_event(i2cscr_pkg::OP_SHIFT, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, 8'h7E);
    push_event(i2cscr_pkg::OP_SHIFT, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, 8'hFF);
    push_event(i2cscr_pkg::OP_STOP, 8'h00);
    // address mismatch
    push_event(i2cscr_pkg::OP_START, 8'h00);
    push_event(i2cscr_pkg::OP_SHIFT, 8'hFE);

    // random transfers under several register settings
    for (int p = 0; p < NumSettings; p++) begin
      wait_drained();
      case (p)
        1: write_all(7'h7F, 8'hFF, 8'h00, 8'hC0, 8'h00);
        2: write_all(7'h00, 8'h10, 8'h10, 8'hFF, 8'hFF);
        3: begin
          code = 8'($urandom);
          write_all(7'($urandom), code, code, code, 8'($urandom));
        end
        4: write_all(7'($urandom), 8'($urandom), 8'($urandom), 8'h7F, 8'h00);
        5: write_all(7'($urandom), 8'h00, 8'hFF, {2'b11, 6'($urandom)}, 8'hC0);
        6: write_all(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      mark = queued_cnt;
      while (queued_cnt - mark < ItemsPerSetting) gen_transfer();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0 && reply_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/i2cscr_pkg.sv
hdl/i2c_slave_command_responder.sv
tb/i2c_slave_command_responder_tb.sv
